@@ hdl/bsw_pkg.sv @@
// ----------------------------------------------------------------------------
// bsw_pkg
// Shared constants for the box-sum window filter: configuration register
// layout, register indexes, reset values and output queue depth.
// ----------------------------------------------------------------------------
`default_nettype none

package bsw_pkg;

  // Configuration register widths
  localparam int CFG_W     = 11;
  localparam int RAD_W     = 3;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 1'd1;

  // Configuration reset values
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH = 11'd1024;
  localparam logic [RAD_W-1:0] RST_RADIUS      = 3'd1;

  // Result queue depth; bounds the number of transactions in flight
  localparam int FIFO_DEPTH = 8;

endpackage

`default_nettype wire

@@ hdl/bsw_if.sv @@
// ----------------------------------------------------------------------------
// bsw_in_if / bsw_out_if
// Valid/ready stream channels for the box-sum window filter: the sample
// stream into the block and the window-sum stream out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsw_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface bsw_out_if #(
  parameter int SUM_BITS = 24
);
  logic                valid;
  logic                ready;
  logic [SUM_BITS-1:0] box_sum;
  logic                frame_last;

  modport source (output valid, output box_sum, output frame_last, input ready);
  modport sink   (input valid, input box_sum, input frame_last, output ready);
endinterface

`default_nettype wire

@@ hdl/bsw_hist_ram.sv @@
// ----------------------------------------------------------------------------
// bsw_hist_ram
// Line history memory: one word per image column, holding that column's
// sample of every row in the history. One write and one registered read
// port; a read at the address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_hist_ram #(
  parameter int DEPTH = 1024,
  parameter int DW    = 240
) (
  input  wire          clk,
  input  wire          rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  wire          wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bsw_out_fifo.sv @@
// ----------------------------------------------------------------------------
// bsw_out_fifo
// Result queue between the sum pipeline and the output channel. Absorbs
// results while the receiver stalls so the pipeline never has to hold.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_out_fifo
  import bsw_pkg::*;
#(
  parameter int DW = 25
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire [DW-1:0] push_data,
  output logic         out_valid,
  input  wire          out_ready,
  output logic [DW-1:0] out_data
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [DW-1:0]    store_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_data  = store_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/box_sum_window_filter.sv @@
// ----------------------------------------------------------------------------
// box_sum_window_filter
// Streaming square box-sum filter over an N by N raster image.
//
// Channels: in_ch carries one sample per transaction (sample, frame_start);
// out_ch carries one window sum per transaction (box_sum, frame_last).
// Only positions whose whole (2R+1) by (2R+1) window lies inside the image
// produce a result, so a frame yields (N-2R) by (N-2R) sums in raster order.
// cfg_wr_en/cfg_addr/cfg_wdata write image_width (0) and radius (1); write
// them only while no transaction is in flight.
// Throughput: one sample per cycle while in_ch.ready is high. Each sample
// costs one read-modify-write of its column word in the line history memory;
// back-to-back samples on the same column are forwarded around the memory.
// A result passes the memory read, the column sum in two steps and the
// window sum in two steps before it can be taken.
// Stall: an 8-entry result queue absorbs receiver stalls; in_ch.ready
// drops once 8 transactions are accepted and not yet retired.
// Reset: positions, configuration (width 1024, radius 1) and the column
// sum window clear at once; there is no clearing pass over the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module box_sum_window_filter
  import bsw_pkg::*;
#(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RADIUS  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  bsw_in_if.sink              in_ch,
  bsw_out_if.source           out_ch,
  input  wire                 cfg_wr_en,
  input  wire [CFG_IDX_W-1:0] cfg_addr,
  input  wire [CFG_W-1:0]     cfg_wdata
);

  localparam int HR     = 2 * MAX_RADIUS + 1;
  localparam int SLOT_W = $clog2(HR);
  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int N_W    = $clog2(MAX_WIDTH + 1);
  localparam int CS_W   = SAMPLE_BITS + $clog2(HR);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(HR * HR);
  localparam int WORD_W = HR * SAMPLE_BITS;
  localparam int NG     = (HR + 3) / 4;
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(HR - 1)) ? '0 : s + 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_width_r;
  logic [RAD_W-1:0] cfg_radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= RST_IMAGE_WIDTH;
      cfg_radius_r <= RST_RADIUS;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_IMAGE_WIDTH: cfg_width_r  <= cfg_wdata;
        REG_RADIUS:      cfg_radius_r <= cfg_wdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and radius to what the storage supports
  logic [N_W-1:0]    n_eff;
  logic [RAD_W-1:0]  rad_eff;
  logic [SLOT_W-1:0] span;

  always_comb begin
    if (cfg_width_r == '0) begin
      n_eff = N_W'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      n_eff = N_W'(MAX_WIDTH);
    end else begin
      n_eff = N_W'(cfg_width_r);
    end
    rad_eff = (32'(cfg_radius_r) > 32'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : cfg_radius_r;
    span    = SLOT_W'({rad_eff, 1'b0});
  end

  // --------------------------------------------------------------------------
  // Transaction accounting: items in the pipeline plus queued results
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] pend_r;
  logic             accept;
  logic             pop;
  logic             drop;
  logic             push;

  assign in_ch.ready = (pend_r < CNT_W'(FIFO_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(drop);
    end
  end

  // --------------------------------------------------------------------------
  // Position tracking: row, column and history slot of the current sample
  // --------------------------------------------------------------------------
  logic [POS_W-1:0]  col_pos_r, row_pos_r;
  logic [SLOT_W-1:0] slot_pos_r;
  logic [POS_W-1:0]  col_c, row_c, col_nxt, row_nxt;
  logic [SLOT_W-1:0] slot_c, slot_nxt, rowsat_c;
  logic              emit_c, last_c;

  always_comb begin
    logic [N_W-1:0]    c0, r0, r1, cn, rn;
    logic [SLOT_W-1:0] s0, s1;
    // start of frame or carried position
    c0 = in_ch.frame_start ? '0 : N_W'(col_pos_r);
    r0 = in_ch.frame_start ? '0 : N_W'(row_pos_r);
    s0 = in_ch.frame_start ? '0 : slot_pos_r;
    // wrap a column past the width
    if (c0 >= n_eff) begin
      col_c = '0;
      r1    = r0 + 1'b1;
      s1    = slot_inc(s0);
    end else begin
      col_c = POS_W'(c0);
      r1    = r0;
      s1    = s0;
    end
    // wrap a row past the height
    if (r1 >= n_eff) begin
      row_c  = '0;
      slot_c = '0;
    end else begin
      row_c  = POS_W'(r1);
      slot_c = s1;
    end
    // advance for the next sample
    cn = N_W'(col_c) + 1'b1;
    rn = N_W'(row_c) + 1'b1;
    if (cn >= n_eff) begin
      col_nxt = '0;
      if (rn >= n_eff) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = POS_W'(rn);
        slot_nxt = slot_inc(slot_c);
      end
    end else begin
      col_nxt  = POS_W'(cn);
      row_nxt  = row_c;
      slot_nxt = slot_c;
    end
    rowsat_c = (32'(row_c) >= 32'(HR - 1)) ? SLOT_W'(HR - 1) : SLOT_W'(row_c);
    emit_c   = (32'(row_c) >= 32'(span)) && (32'(col_c) >= 32'(span));
    last_c   = (N_W'(row_c) == n_eff - 1'b1) && (N_W'(col_c) == n_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r  <= '0;
      row_pos_r  <= '0;
      slot_pos_r <= '0;
    end else if (accept) begin
      col_pos_r  <= col_nxt;
      row_pos_r  <= row_nxt;
      slot_pos_r <= slot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: history read-modify-write with same-column forwarding
  // --------------------------------------------------------------------------
  logic                   a_vld_r;
  logic [POS_W-1:0]       a_col_r;
  logic [SLOT_W-1:0]      a_slot_r, a_rowsat_r, a_span_r;
  logic [SAMPLE_BITS-1:0] a_sample_r;
  logic                   a_emit_r, a_last_r;
  logic                   fwd_r;
  logic [WORD_W-1:0]      fwd_word_r;
  logic [WORD_W-1:0]      ram_rdata;
  logic [WORD_W-1:0]      word_mod;

  bsw_hist_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (WORD_W)
  ) u_hist_ram (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_c),
    .rd_data (ram_rdata),
    .wr_en   (a_vld_r),
    .wr_addr (a_col_r),
    .wr_data (word_mod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      fwd_r   <= 1'b0;
    end else begin
      a_vld_r <= accept;
      fwd_r   <= accept && a_vld_r && (a_col_r == col_c);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_col_r    <= col_c;
      a_slot_r   <= slot_c;
      a_rowsat_r <= rowsat_c;
      a_span_r   <= span;
      a_sample_r <= in_ch.sample;
      a_emit_r   <= emit_c;
      a_last_r   <= last_c;
      fwd_word_r <= word_mod;
    end
  end

  // Insert the new sample and mask the rows outside the window
  logic [SAMPLE_BITS-1:0] lane_m [HR];
  logic [CS_W-1:0]        b_part_nxt [NG];

  always_comb begin
    logic [SLOT_W-1:0] lag;
    logic [CS_W-1:0]   acc;
    word_mod = fwd_r ? fwd_word_r : ram_rdata;
    word_mod[a_slot_r * SAMPLE_BITS +: SAMPLE_BITS] = a_sample_r;
    for (int s = 0; s < HR; s++) begin
      if (a_slot_r >= SLOT_W'(s)) begin
        lag = a_slot_r - SLOT_W'(s);
      end else begin
        lag = a_slot_r + SLOT_W'(HR - s);
      end
      if (lag <= a_span_r && lag <= a_rowsat_r) begin
        lane_m[s] = word_mod[s * SAMPLE_BITS +: SAMPLE_BITS];
      end else begin
        lane_m[s] = '0;
      end
    end
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < HR) begin
          acc = acc + CS_W'(lane_m[g * 4 + j]);
        end
      end
      b_part_nxt[g] = acc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: finish the column sum and shift it into the window
  // --------------------------------------------------------------------------
  logic                 b_vld_r;
  logic [SLOT_W-1:0]    b_span_r;
  logic                 b_emit_r, b_last_r;
  logic [CS_W-1:0]      b_part_r [NG];
  logic [CS_W-1:0]      cs_c;
  logic [CS_W-1:0]      recent_r [HR];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    b_span_r <= a_span_r;
    b_emit_r <= a_emit_r;
    b_last_r <= a_last_r;
    for (int g = 0; g < NG; g++) begin
      b_part_r[g] <= b_part_nxt[g];
    end
  end

  always_comb begin
    cs_c = '0;
    for (int g = 0; g < NG; g++) begin
      cs_c = cs_c + b_part_r[g];
    end
  end

  // Column sums of the most recent samples, newest first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HR; k++) begin
        recent_r[k] <= '0;
      end
    end else if (b_vld_r) begin
      recent_r[0] <= cs_c;
      for (int k = 1; k < HR; k++) begin
        recent_r[k] <= recent_r[k - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: partial window sums over the newest span+1 column sums
  // --------------------------------------------------------------------------
  logic              c_vld_r;
  logic [SLOT_W-1:0] c_span_r;
  logic              c_emit_r, c_last_r;
  logic [SUM_W-1:0]  d_part_nxt [NG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    c_span_r <= b_span_r;
    c_emit_r <= b_emit_r;
    c_last_r <= b_last_r;
  end

  always_comb begin
    logic [SUM_W-1:0] acc;
    for (int g = 0; g < NG; g++) begin
      acc = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < HR) begin
          if (SLOT_W'(g * 4 + j) <= c_span_r) begin
            acc = acc + SUM_W'(recent_r[g * 4 + j]);
          end
        end
      end
      d_part_nxt[g] = acc;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: window total, then queue or retire the transaction
  // --------------------------------------------------------------------------
  logic             d_vld_r;
  logic             d_emit_r, d_last_r;
  logic [SUM_W-1:0] d_part_r [NG];
  logic [SUM_W-1:0] total_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    d_emit_r <= c_emit_r;
    d_last_r <= c_last_r;
    for (int g = 0; g < NG; g++) begin
      d_part_r[g] <= d_part_nxt[g];
    end
  end

  always_comb begin
    total_c = '0;
    for (int g = 0; g < NG; g++) begin
      total_c = total_c + d_part_r[g];
    end
  end

  assign push = d_vld_r && d_emit_r;
  assign drop = d_vld_r && !d_emit_r;

  bsw_out_fifo #(
    .DW (SUM_W + 1)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({d_last_r, total_c}),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  ({out_ch.frame_last, out_ch.box_sum})
  );

endmodule

`default_nettype wire
